// ===== sv/antialiased_line_rasterizer_defines.svh =====
// ----------------------------------------------------------------------------
// Anti-aliased line rasterizer assertion macros
// Shared assertion forms for the rasterizer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_LINE_RASTERIZER_DEFINES_SVH
`define ANTIALIASED_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ALR_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rasterizer check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ALR_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rasterizer check failed: next-cycle implication");

`endif

// ===== sv/alr_pkg.sv =====
// ----------------------------------------------------------------------------
// Anti-aliased line rasterizer package
// Widths, sequencer codes and the divider request and status types.
// ----------------------------------------------------------------------------
package alr_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int PIX_BITS   = COORD_BITS + 1;
    localparam int COV_BITS   = FRAC_BITS + 1;
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int STEP_BITS  = FRAC_BITS + 2;
    localparam int DIV_STEPS  = COORD_BITS + FRAC_BITS;
    localparam int CNT_BITS   = $clog2(DIV_STEPS + 1);

    localparam logic [COV_BITS-1:0] ONE_Q = COV_BITS'(1) << FRAC_BITS;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PIX0 = 2'd2;
    localparam logic [1:0] ST_PIX1 = 2'd3;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] num;
        logic [COORD_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [QUO_BITS-1:0] quot;
    } div_sts_t;

endpackage

// ===== sv/alr_div.sv =====
// ----------------------------------------------------------------------------
// Anti-aliased line rasterizer divider
// Restoring divider giving floor(num * 2^FRAC_BITS / den), one bit a cycle.
// ----------------------------------------------------------------------------
module alr_div
    import alr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_sts_t sts
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [COORD_BITS-1:0] den_reg, den_next;
    logic [DIV_STEPS-1:0]  dvd_reg, dvd_next;
    logic [QUO_BITS-1:0]   quo_reg, quo_next;
    logic [COORD_BITS:0]   shifted;
    logic [COORD_BITS:0]   trial;
    logic                  fits;

    assign shifted = {rem_reg, dvd_reg[DIV_STEPS-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = req.den;
            dvd_next  = {req.num, {FRAC_BITS{1'b0}}};
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
            dvd_next = {dvd_reg[DIV_STEPS-2:0], 1'b0};
            quo_next = {quo_reg[QUO_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sts.quot = quo_reg;

endmodule

// ===== sv/antialiased_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Anti-aliased line rasterizer
// Wu-style line stepping in Q16 fixed point, two coverage pixels per step.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   action, start_x, start_y, end_x, end_y
//   out      out_valid / out_ready pixel_x, pixel_y, coverage, last
//
// A start transfer loads the line and then runs the bit-serial divider,
// except for a vertical line, which needs no division.
// After a step transfer its two pixels leave one per cycle while out_ready is high.
// A step while no line is active gives no pixels.
// The input is not ready while a division or a pixel pair is outstanding.
// Reset is asynchronous and leaves the block idle with no active line.
// ----------------------------------------------------------------------------
`include "antialiased_line_rasterizer_defines.svh"

module antialiased_line_rasterizer
    import alr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_BITS-1:0]   pixel_x,
    output logic [PIX_BITS-1:0]   pixel_y,
    output logic [COV_BITS-1:0]   coverage,
    output logic                  last
);

    logic [1:0]            state_reg, state_next;
    logic                  active_reg, active_next;
    logic                  steep_reg, steep_next;
    logic                  down_reg, down_next;
    logic                  neg_reg, neg_next;
    logic [PIX_BITS-1:0]   major_pos_reg, major_pos_next;
    logic [COORD_BITS-1:0] major_end_reg, major_end_next;
    logic [ACC_BITS-1:0]   minor_acc_reg, minor_acc_next;
    logic [STEP_BITS-1:0]  minor_step_reg, minor_step_next;

    logic                  in_xfer;
    logic                  out_xfer;
    logic                  swap;
    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    logic [COORD_BITS-1:0] dx, ady;
    logic                  neg;
    logic                  steep;
    logic [PIX_BITS-1:0]   floor_pos;
    logic [FRAC_BITS-1:0]  frac;
    logic [PIX_BITS-1:0]   minor_pix;
    logic                  fin;
    logic [STEP_BITS-1:0]  quot_ext;
    div_req_t              div_req;
    div_sts_t              div_sts;

    alr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .sts   (div_sts)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_PIX0) || (state_reg == ST_PIX1);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;

    assign swap  = end_x < start_x;
    assign sx    = swap ? end_x : start_x;
    assign sy    = swap ? end_y : start_y;
    assign ex    = swap ? start_x : end_x;
    assign ey    = swap ? start_y : end_y;
    assign dx    = ex - sx;
    assign neg   = ey < sy;
    assign ady   = neg ? sy - ey : ey - sy;
    assign steep = (dx == '0) || (ady >= dx);

    assign div_req.start = in_xfer && (action == ACT_START) && (dx != '0);
    assign div_req.num   = steep ? dx : ady;
    assign div_req.den   = steep ? ady : dx;

    assign quot_ext = {1'b0, div_sts.quot};

    assign floor_pos = minor_acc_reg[ACC_BITS-1:FRAC_BITS];
    assign frac      = minor_acc_reg[FRAC_BITS-1:0];
    assign fin       = major_pos_reg == {1'b0, major_end_reg};
    assign minor_pix = (state_reg == ST_PIX0) ? floor_pos + 1'b1 : floor_pos;

    assign pixel_x  = steep_reg ? minor_pix : major_pos_reg;
    assign pixel_y  = steep_reg ? major_pos_reg : minor_pix;
    assign coverage = (state_reg == ST_PIX0) ? {1'b0, frac} : ONE_Q - {1'b0, frac};
    assign last     = (state_reg == ST_PIX1) && fin;

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        steep_next      = steep_reg;
        down_next       = down_reg;
        neg_next        = neg_reg;
        major_pos_next  = major_pos_reg;
        major_end_next  = major_end_reg;
        minor_acc_next  = minor_acc_reg;
        minor_step_next = minor_step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (action == ACT_START)
                    begin
                        active_next     = 1'b1;
                        steep_next      = steep;
                        down_next       = steep && neg;
                        neg_next        = neg;
                        major_pos_next  = {1'b0, steep ? sy : sx};
                        major_end_next  = steep ? ey : ex;
                        minor_acc_next  = {1'b0, steep ? sx : sy, {FRAC_BITS{1'b0}}};
                        minor_step_next = '0;
                        if (dx != '0)
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    else if (active_reg)
                    begin
                        state_next = ST_PIX0;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    minor_step_next = (!steep_reg && neg_reg) ? -quot_ext : quot_ext;
                    state_next      = ST_IDLE;
                end
            end
            ST_PIX0:
            begin
                if (out_xfer)
                begin
                    state_next = ST_PIX1;
                end
            end
            ST_PIX1:
            begin
                if (out_xfer)
                begin
                    state_next = ST_IDLE;
                    if (fin)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        major_pos_next = down_reg ? major_pos_reg - 1'b1
                                                  : major_pos_reg + 1'b1;
                        minor_acc_next = minor_acc_reg
                                       + {{(ACC_BITS-STEP_BITS){minor_step_reg[STEP_BITS-1]}},
                                          minor_step_reg};
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= 1'b0;
            steep_reg      <= 1'b0;
            down_reg       <= 1'b0;
            neg_reg        <= 1'b0;
            major_pos_reg  <= '0;
            major_end_reg  <= '0;
            minor_acc_reg  <= '0;
            minor_step_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            steep_reg      <= steep_next;
            down_reg       <= down_next;
            neg_reg        <= neg_next;
            major_pos_reg  <= major_pos_next;
            major_end_reg  <= major_end_next;
            minor_acc_reg  <= minor_acc_next;
            minor_step_reg <= minor_step_next;
        end
    end

    `ALR_ASSERT_NOW(a_div_done_in_div, div_sts.done, state_reg == ST_DIV)
    `ALR_ASSERT_NOW(a_div_idle_outside, state_reg != ST_DIV, !div_sts.busy && !div_sts.done)
    `ALR_ASSERT_NEXT(a_pair_order, (state_reg == ST_PIX0) && out_ready, state_reg == ST_PIX1)
    `ALR_ASSERT_NEXT(a_last_ends_line, out_valid && out_ready && last, !active_reg)

endmodule
